// ===== design/assert_macros.svh =====
// Assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// ===== design/brwf_pkg.sv =====
`default_nettype none
package brwf_pkg;

   // CAPACITY must be a power of two; bytes are spread over BANKS banks
   localparam int CAPACITY = 1024;
   localparam int BANKS    = 8;
   localparam int BANK_W   = $clog2(BANKS);
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int ROWS     = CAPACITY / BANKS;
   localparam int ROW_W    = $clog2(ROWS);
   localparam int BYTE_W   = 8;
   localparam int OP_W     = 2;
   localparam int LEN_W    = 4;
   localparam int VAL_W    = 64;
   localparam int STAT_W   = 2;
   localparam int FILL_W   = 10;
   localparam int FREE_W   = 11;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_SHORT   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NO_ROOM = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [LEN_W-1:0] num_bytes;
      logic [VAL_W-1:0] write_value;
      logic             sign_extend;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0]  read_value;
      logic [STAT_W-1:0] status;
      logic [FILL_W-1:0] fill_level;
      logic [FREE_W-1:0] free_space;
   } rsp_type;

   typedef struct packed {
      logic              read_ok;
      logic [LEN_W-1:0]  len;
      logic [BANK_W-1:0] bank_base;
      logic              sign_extend;
      logic [STAT_W-1:0] status;
      logic [FILL_W-1:0] fill;
      logic [FREE_W-1:0] free;
   } pend_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

endpackage
`default_nettype wire

// ===== design/brwf_ram.sv =====
`default_nettype none
module brwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/byte_ring_word_fifo.sv =====
// An accepted word is held in pend_ff; the banked byte memory is written or read at
// the accept edge and its registered read data is assembled in the next cycle (S_READ)
// and loaded into rsp_ff. A new word waits for S_IDLE and for the last result to go.
// Reset: synchronous, clears both pointers, the sequencer and the result valid.
// The byte memory is not cleared; no clearing pass, words are taken at once.
`default_nettype none
`include "assert_macros.svh"
module byte_ring_word_fifo
   import brwf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   pend_type         pend_ff, pend_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_load;
   logic             req_fire;

   logic [LEN_W-1:0]  len;
   logic [PTR_W-1:0]  fill_now;
   logic [PTR_W-1:0]  fill_after;
   logic              push_fits;
   logic              read_fits;
   logic              push_ok;
   logic [STAT_W-1:0] status;
   logic [PTR_W-1:0]  base;

   logic [ROW_W-1:0]  bank_addr [BANKS];
   logic              bank_we   [BANKS];
   logic [BYTE_W-1:0] bank_wd   [BANKS];
   logic [BYTE_W-1:0] bank_rd   [BANKS];

   logic [VAL_W-1:0]  word_left;
   logic [VAL_W-1:0]  word_out;

   assign req_fire = req_valid && req_ready;
   assign len      = (req_data.num_bytes > MAX_LEN) ? MAX_LEN : req_data.num_bytes;
   assign fill_now = wp_ff - rp_ff;
   assign push_fits = ({1'b0, fill_now} + (PTR_W+1)'(len)) < (PTR_W+1)'(CAPACITY);
   assign read_fits = (fill_now != '0) && (PTR_W'(len) <= fill_now);

   always_comb begin
      rp_in   = rp_ff;
      wp_in   = wp_ff;
      status  = STATUS_OK;
      push_ok = 1'b0;
      unique case (req_data.opcode)
         OP_PUSH: begin
            if (push_fits) begin
               push_ok = 1'b1;
               wp_in   = wp_ff + PTR_W'(len);
            end else begin
               rp_in  = '0;
               wp_in  = '0;
               status = STATUS_NO_ROOM;
            end
         end
         OP_POP: begin
            if (read_fits) begin
               rp_in = rp_ff + PTR_W'(len);
            end else begin
               status = STATUS_SHORT;
            end
         end
         OP_PEEK: begin
            if (!read_fits) begin
               status = STATUS_SHORT;
            end
         end
         OP_CLEAR: begin
            rp_in = '0;
            wp_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign fill_after = wp_in - rp_in;

   always_comb begin
      pend_in.read_ok     = (req_data.opcode == OP_POP || req_data.opcode == OP_PEEK)
                            && read_fits && (len != '0);
      pend_in.len         = len;
      pend_in.bank_base   = rp_ff[BANK_W-1:0];
      pend_in.sign_extend = req_data.sign_extend;
      pend_in.status      = status;
      pend_in.fill        = FILL_W'(fill_after);
      pend_in.free        = FREE_W'(CAPACITY) - FREE_W'(fill_after);
   end

   // byte i of the span lands in bank (base + i) mod BANKS, so each bank sees one access
   assign base = (req_data.opcode == OP_PUSH) ? wp_ff : rp_ff;

   always_comb begin
      logic [BANK_W-1:0] off;
      logic [PTR_W-1:0]  addr;
      logic [LEN_W-1:0]  k;
      for (int b = 0; b < BANKS; b++) begin
         off          = BANK_W'(b) - base[BANK_W-1:0];
         addr         = base + PTR_W'(off);
         k            = len - LEN_W'(1) - LEN_W'(off);
         bank_addr[b] = addr[PTR_W-1:BANK_W];
         bank_we[b]   = req_fire && push_ok && (LEN_W'(off) < len);
         bank_wd[b]   = req_data.write_value[{k[BANK_W-1:0], 3'b000} +: BYTE_W];
      end
   end

   for (genvar g = 0; g < BANKS; g++) begin : g_bank
      brwf_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we[g]),
         .addr    (bank_addr[g]),
         .wr_data (bank_wd[g]),
         .rd_data (bank_rd[g])
      );
   end

   always_comb begin
      logic [BANK_W-1:0] sel;
      for (int i = 0; i < BANKS; i++) begin
         sel = pend_ff.bank_base + BANK_W'(i);
         word_left[VAL_W-1-BYTE_W*i -: BYTE_W] = bank_rd[sel];
      end
   end

   always_comb begin
      logic [BANK_W-1:0] drop;
      logic [5:0]        shamt;
      drop  = BANK_W'(MAX_LEN - pend_ff.len);
      shamt = {drop, 3'b000};
      if (pend_ff.sign_extend) begin
         word_out = $unsigned($signed(word_left) >>> shamt);
      end else begin
         word_out = word_left >> shamt;
      end
   end

   always_comb begin
      rsp_in.read_value = pend_ff.read_ok ? word_out : '0;
      rsp_in.status     = pend_ff.status;
      rsp_in.fill_level = pend_ff.fill;
      rsp_in.free_space = pend_ff.free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
         end
         S_READ: begin
            rsp_load = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            rp_ff <= rp_in;
            wp_ff <= wp_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_ff <= pend_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEXT(a_no_back_to_back, clock, reset, req_fire, !req_ready)
   `ASSERT_NEXT(a_result_follows, clock, reset, state_ff == S_READ, rsp_valid_ff)
   `ASSERT_SAME(a_level_sum, clock, reset, rsp_valid_ff, (FREE_W'(rsp_ff.fill_level) + rsp_ff.free_space) == FREE_W'(CAPACITY))
   `ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid_ff && rsp_ff.status != STATUS_OK, rsp_ff.read_value == '0)

endmodule
`default_nettype wire
